// ----- sv/tlc_pkg.sv -----
// ----------------------------------------------------------------------------
// tlc_pkg: shared types and constants for the touched LOD cells unit
// Field widths, register indexes and the structs that pass between the
// divider lanes, the sequencer and the cell emitter.
// ----------------------------------------------------------------------------
package tlc_pkg;

   localparam int AXES       = 3;
   localparam int CELL_W     = 33;
   localparam int SPAN_W     = 13;
   localparam int LEVEL_W    = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;
   localparam int IN_W       = 32;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_SPAN  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL = 1'd1;

   // controls from the sequencer to every divider lane
   typedef struct packed {
      logic load;
      logic step;
   } div_ctl_type;

   // one axis after division: first cell and number of cells (1 to 3)
   typedef struct packed {
      logic [CELL_W-1:0] start;
      logic [1:0]        count;
   } axis_type;

   typedef axis_type [AXES-1:0] axis_set_type;

   // handoff from the sequencer to the emitter
   typedef struct packed {
      logic               load;
      logic [LEVEL_W-1:0] level;
      axis_set_type       axis;
   } emit_load_type;

endpackage

// ----- sv/tlc_axis_div.sv -----
// ----------------------------------------------------------------------------
// tlc_axis_div: bit-serial floor divider for one axis
// Restoring division, one quotient bit per step. A negative coordinate is
// divided as its complement, and the floor quotient and remainder flags are
// recovered from that, so no signed correction pass is needed.
// ----------------------------------------------------------------------------
module tlc_axis_div #(
   parameter int COORD_BITS = 32
) (
   input  logic                       clock,
   input  tlc_pkg::div_ctl_type       ctl,
   input  logic [COORD_BITS-1:0]      coord,
   input  logic [tlc_pkg::SPAN_W-1:0] span,
   output tlc_pkg::axis_type          result
);
   import tlc_pkg::*;

   localparam int MAG_W = COORD_BITS - 1;

   logic [MAG_W-1:0]  quo_ff, quo_in;
   logic [SPAN_W-1:0] rem_ff, rem_in;
   logic              neg_ff, neg_in;
   logic [SPAN_W:0]   trial;
   logic              fits;
   logic [SPAN_W-1:0] span_m1;
   logic              rem_zero, rem_top, lo, hi;
   logic [CELL_W-1:0] q_ext, q_val;

   // shift one dividend bit into the partial remainder and subtract on fit
   always_comb begin
      trial  = {rem_ff, quo_ff[MAG_W-1]};
      fits   = trial >= {1'b0, span};
      quo_in = quo_ff;
      rem_in = rem_ff;
      neg_in = neg_ff;
      if (ctl.load) begin
         neg_in = coord[COORD_BITS-1];
         quo_in = coord[COORD_BITS-1] ? ~coord[MAG_W-1:0] : coord[MAG_W-1:0];
         rem_in = '0;
      end else if (ctl.step) begin
         quo_in = {quo_ff[MAG_W-2:0], fits};
         rem_in = fits ? SPAN_W'(trial - {1'b0, span}) : trial[SPAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   // a complemented remainder swaps the zero and span-1 cases
   always_comb begin
      span_m1  = span - SPAN_W'(1);
      rem_zero = rem_ff == '0;
      rem_top  = rem_ff == span_m1;
      lo       = neg_ff ? rem_top : rem_zero;
      hi       = neg_ff ? rem_zero : rem_top;
      q_ext    = {{(CELL_W-MAG_W){1'b0}}, quo_ff};
      q_val    = neg_ff ? ~q_ext : q_ext;
      result.start = lo ? q_val - CELL_W'(1) : q_val;
      result.count = 2'd1 + {1'b0, lo} + {1'b0, hi};
   end

endmodule

// ----- sv/tlc_emitter.sv -----
// ----------------------------------------------------------------------------
// tlc_emitter: cell emitter
// Walks the offset combinations of one chunk, z fastest, one cell per beat,
// from registered cell coordinates. Takes the next chunk on the beat that
// the final cell leaves.
// ----------------------------------------------------------------------------
module tlc_emitter (
   input  logic                        clock,
   input  logic                        reset,
   input  tlc_pkg::emit_load_type      load,
   output logic                        busy,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [tlc_pkg::LEVEL_W-1:0] rsp_cell_level,
   output logic [tlc_pkg::CELL_W-1:0]  rsp_cell_x,
   output logic [tlc_pkg::CELL_W-1:0]  rsp_cell_y,
   output logic [tlc_pkg::CELL_W-1:0]  rsp_cell_z,
   output logic                        rsp_last_cell
);
   import tlc_pkg::*;

   logic                    valid_ff, valid_in;
   logic [LEVEL_W-1:0]      level_ff, level_in;
   logic [CELL_W-1:0]       start_ff [AXES], start_in [AXES];
   logic [CELL_W-1:0]       cell_ff  [AXES], cell_in  [AXES];
   logic [1:0]              cnt_ff   [AXES], cnt_in   [AXES];
   logic [1:0]              idx_ff   [AXES], idx_in   [AXES];
   logic                    last;
   logic                    beat;
   logic                    carry;

   assign last = (idx_ff[0] == cnt_ff[0] - 2'd1) && (idx_ff[1] == cnt_ff[1] - 2'd1)
              && (idx_ff[2] == cnt_ff[2] - 2'd1);
   assign beat = valid_ff && rsp_ready;
   assign busy = valid_ff && !(rsp_ready && last);

   // load a new chunk, or advance the odometer on each beat
   always_comb begin
      valid_in = valid_ff;
      level_in = level_ff;
      carry    = 1'b1;
      for (int a = 0; a < AXES; a++) begin
         start_in[a] = start_ff[a];
         cell_in[a]  = cell_ff[a];
         cnt_in[a]   = cnt_ff[a];
         idx_in[a]   = idx_ff[a];
      end
      priority if (load.load) begin
         valid_in = 1'b1;
         level_in = load.level;
         for (int a = 0; a < AXES; a++) begin
            start_in[a] = load.axis[a].start;
            cell_in[a]  = load.axis[a].start;
            cnt_in[a]   = load.axis[a].count;
            idx_in[a]   = 2'd0;
         end
      end else if (beat && last) begin
         valid_in = 1'b0;
      end else if (beat) begin
         for (int a = AXES - 1; a >= 0; a--) begin
            if (carry) begin
               if (idx_ff[a] == cnt_ff[a] - 2'd1) begin
                  idx_in[a]  = 2'd0;
                  cell_in[a] = start_ff[a];
               end else begin
                  idx_in[a]  = idx_ff[a] + 2'd1;
                  cell_in[a] = cell_ff[a] + CELL_W'(1);
                  carry      = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      level_ff <= level_in;
      for (int a = 0; a < AXES; a++) begin
         start_ff[a] <= start_in[a];
         cell_ff[a]  <= cell_in[a];
         cnt_ff[a]   <= cnt_in[a];
         idx_ff[a]   <= idx_in[a];
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_cell_level = level_ff;
   assign rsp_cell_x     = cell_ff[0];
   assign rsp_cell_y     = cell_ff[1];
   assign rsp_cell_z     = cell_ff[2];
   assign rsp_last_cell  = last;

`ifndef SYNTH
   // the odometer never runs past the cell count of any axis
   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (idx_ff[0] < cnt_ff[0]) && (idx_ff[1] < cnt_ff[1])
                && (idx_ff[2] < cnt_ff[2]))
      else $error("emitter index beyond cell count");

   // the final beat without a new chunk leaves the channel empty
   assert property (@(posedge clock) disable iff (reset)
      (beat && last && !load.load) |=> !valid_ff)
      else $error("emitter still valid after final cell");
`endif

endmodule

// ----- sv/touched_lod_cells_unit.sv -----
// ----------------------------------------------------------------------------
// touched_lod_cells_unit: LOD cells touched by one chunk
// Request channel (req_): one chunk coordinate triple per beat.
// Response channel (rsp_): 1 to 27 cell beats per chunk, ascending in x, then
// y, then z, each tagged with the level register; rsp_last_cell marks the
// final cell of a chunk.
// Config port (csr_): span_chunks (index 0, zero means 1) and lod_level
// (index 1); write only while no chunk is in flight.
// Timing: a chunk passes through the three bit-serial divider lanes (one
// quotient bit per cycle, COORD_BITS-1 steps, plus load and handoff); its
// first cell is valid the cycle after handoff. Cells then leave one per
// cycle while rsp_ready is high. The dividers take the next chunk while the
// emitter still drains cells.
// Reset: span returns to 1, level to 0, the pipe empties.
// Stall: a held rsp_ready freezes the current cell; a finished division
// waits in its lanes, and req_ready stays low until the handoff.
// ----------------------------------------------------------------------------
module touched_lod_cells_unit #(
   parameter int COORD_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [tlc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tlc_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [tlc_pkg::IN_W-1:0]       req_chunk_x,
   input  logic [tlc_pkg::IN_W-1:0]       req_chunk_y,
   input  logic [tlc_pkg::IN_W-1:0]       req_chunk_z,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [tlc_pkg::LEVEL_W-1:0]    rsp_cell_level,
   output logic [tlc_pkg::CELL_W-1:0]     rsp_cell_x,
   output logic [tlc_pkg::CELL_W-1:0]     rsp_cell_y,
   output logic [tlc_pkg::CELL_W-1:0]     rsp_cell_z,
   output logic                           rsp_last_cell
);
   import tlc_pkg::*;

   localparam int STEPS  = COORD_BITS - 1;
   localparam int STEP_W = $clog2(STEPS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [SPAN_W-1:0]  span_ff, span_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [SPAN_W-1:0]  span_eff;
   logic [1:0]         state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               step_last;
   logic               req_beat;
   logic               emit_busy;
   div_ctl_type        div_ctl;
   axis_set_type       axis_res;
   emit_load_type      emit_load;

   // configuration registers
   always_comb begin
      span_in  = span_ff;
      level_in = level_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SPAN:  span_in  = csr_wdata;
            CSR_LEVEL: level_in = csr_wdata[LEVEL_W-1:0];
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff  <= SPAN_W'(1);
         level_ff <= '0;
      end else begin
         span_ff  <= span_in;
         level_ff <= level_in;
      end
   end

   assign span_eff = (span_ff == '0) ? SPAN_W'(1) : span_ff;

   // sequence load, division steps and handoff
   assign req_ready = state_ff == ST_IDLE;
   assign req_beat  = req_valid && req_ready;
   assign step_last = step_ff == STEP_W'(STEPS - 1);

   always_comb begin
      state_in        = state_ff;
      step_in         = step_ff;
      div_ctl.load    = req_beat;
      div_ctl.step    = state_ff == ST_DIV;
      emit_load.load  = 1'b0;
      emit_load.level = level_ff;
      emit_load.axis  = axis_res;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (req_valid) state_in = ST_DIV;
         end
         ST_DIV: begin
            step_in = step_ff + STEP_W'(1);
            if (step_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!emit_busy) begin
               emit_load.load = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // one divider lane per axis
   tlc_axis_div #(.COORD_BITS(COORD_BITS)) u_div_x (
      .clock  (clock),
      .ctl    (div_ctl),
      .coord  (req_chunk_x[COORD_BITS-1:0]),
      .span   (span_eff),
      .result (axis_res[0])
   );

   tlc_axis_div #(.COORD_BITS(COORD_BITS)) u_div_y (
      .clock  (clock),
      .ctl    (div_ctl),
      .coord  (req_chunk_y[COORD_BITS-1:0]),
      .span   (span_eff),
      .result (axis_res[1])
   );

   tlc_axis_div #(.COORD_BITS(COORD_BITS)) u_div_z (
      .clock  (clock),
      .ctl    (div_ctl),
      .coord  (req_chunk_z[COORD_BITS-1:0]),
      .span   (span_eff),
      .result (axis_res[2])
   );

   tlc_emitter u_emitter (
      .clock          (clock),
      .reset          (reset),
      .load           (emit_load),
      .busy           (emit_busy),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cell_level (rsp_cell_level),
      .rsp_cell_x     (rsp_cell_x),
      .rsp_cell_y     (rsp_cell_y),
      .rsp_cell_z     (rsp_cell_z),
      .rsp_last_cell  (rsp_last_cell)
   );

`ifndef SYNTH
   // an accepted chunk starts division from step zero
   assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == ST_DIV) && (step_ff == '0))
      else $error("division did not start on accepted chunk");

   // the last division step always ends in the handoff state
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && step_last) |=> state_ff == ST_DONE)
      else $error("division overran its step count");
`endif

endmodule
